>>> src/pwgm_pkg.sv
// Shared types and constants for the plane-wave g-vector mask pipeline.
// No dependencies; every other file in src refers to it by scoped names.
`default_nettype none

package pwgm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register index map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASIS_X  = 3'd0,
    REG_BASIS_Y  = 3'd1,
    REG_BASIS_Z  = 3'd2,
    REG_SCALE    = 3'd3,
    REG_CUTOFF   = 3'd4,
    REG_GAMMA    = 3'd5,
    REG_OFFSETS  = 3'd6,
    REG_DIMS     = 3'd7
  } reg_idx_t;

  localparam logic [15:0] SCALE_RST = 16'd256;
  localparam logic [26:0] DIMS_RST  = 27'd67240192;

  localparam logic signed [23:0] G_MAX = 24'sd8388607;
  localparam logic signed [23:0] G_MIN = -24'sd8388608;

  typedef struct packed {
    logic [47:0] basis_x;
    logic [47:0] basis_y;
    logic [47:0] basis_z;
    logic [15:0] scale;
    logic [47:0] cutoff;
    logic        gamma_only;
    logic [23:0] offsets;
    logic [26:0] dims;
  } cfg_t;

  // folded indices plus the early reject (gamma half-space or Nyquist)
  typedef struct packed {
    logic signed [8:0] idx_x;
    logic signed [8:0] idx_y;
    logic signed [8:0] idx_z;
    logic              rej;
  } fold_t;

  typedef struct packed {
    logic signed [8:0]  idx_x;
    logic signed [8:0]  idx_y;
    logic signed [8:0]  idx_z;
    logic signed [23:0] g_x;
    logic signed [23:0] g_y;
    logic signed [23:0] g_z;
    logic               rej;
  } gvec_t;

  // one row of the reciprocal matrix times the index vector, exact
  function automatic logic signed [26:0] dot3(input logic [47:0] row,
                                              input logic signed [8:0] x,
                                              input logic signed [8:0] y,
                                              input logic signed [8:0] z);
    logic signed [24:0] p0;
    logic signed [24:0] p1;
    logic signed [24:0] p2;
    p0 = x * $signed(row[15:0]);
    p1 = y * $signed(row[31:16]);
    p2 = z * $signed(row[47:32]);
    return $signed({{2{p0[24]}}, p0}) + $signed({{2{p1[24]}}, p1})
         + $signed({{2{p2[24]}}, p2});
  endfunction

endpackage

`default_nettype wire

>>> src/plane_wave_gvector_mask.sv
// plane_wave_gvector_mask: six register stages. One word per cycle sustained while
// out_stall is low; the 27x17 scale multipliers of stage 3 and the 24x24 squarers of
// stage 5 set the critical path. Each stage has its own valid and ready, so bubbles
// are squeezed out under stall. Synchronous active-low reset clears all valids and
// loads the register defaults (scale 1.0, dims 256 each, everything else 0).
// Depends on pwgm_pkg, pwgm_cfg, pwgm_fold, pwgm_gvec, pwgm_mag.
`default_nettype none

module plane_wave_gvector_mask #(
  parameter int MAX_DIM = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pwgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pwgm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_local_x,
  input  wire logic [7:0]                      in_local_y,
  input  wire logic [7:0]                      in_local_z,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_in_sphere,
  output logic signed [8:0]                    out_global_x,
  output logic signed [8:0]                    out_global_y,
  output logic signed [8:0]                    out_global_z,
  output logic signed [23:0]                   out_g_x,
  output logic signed [23:0]                   out_g_y,
  output logic signed [23:0]                   out_g_z,
  output logic [47:0]                          out_magnitude_sq
);

  pwgm_pkg::cfg_t  cfg;
  logic            fold_rdy, fold_vld;
  pwgm_pkg::fold_t fold_dat;
  logic            gvec_rdy, gvec_vld;
  pwgm_pkg::gvec_t gvec_dat;
  logic            mag_rdy;

  pwgm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwgm_fold #(.MAX_DIM(MAX_DIM)) u_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .vld_i (in_valid),
    .lx_i  (in_local_x),
    .ly_i  (in_local_y),
    .lz_i  (in_local_z),
    .rdy_o (fold_rdy),
    .vld_o (fold_vld),
    .dat_o (fold_dat),
    .rdy_i (gvec_rdy)
  );

  pwgm_gvec u_gvec (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .vld_i (fold_vld),
    .dat_i (fold_dat),
    .rdy_o (gvec_rdy),
    .vld_o (gvec_vld),
    .dat_o (gvec_dat),
    .rdy_i (mag_rdy)
  );

  pwgm_mag u_mag (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .vld_i            (gvec_vld),
    .dat_i            (gvec_dat),
    .rdy_o            (mag_rdy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_in_sphere    (out_in_sphere),
    .out_global_x     (out_global_x),
    .out_global_y     (out_global_y),
    .out_global_z     (out_global_z),
    .out_g_x          (out_g_x),
    .out_g_y          (out_g_y),
    .out_g_z          (out_g_z),
    .out_magnitude_sq (out_magnitude_sq)
  );

  assign in_stall = !fold_rdy;

endmodule

`default_nettype wire

>>> src/pwgm_cfg.sv
// Configuration register file: basis rows, scale, cutoff, gamma flag, offsets, dims.
// Depends on pwgm_pkg for the register map and the cfg_t bundle.
`default_nettype none

module pwgm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [pwgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pwgm_pkg::CFG_DATA_W-1:0] cfg_data,
  output pwgm_pkg::cfg_t                       cfg
);

  pwgm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.basis_x    <= '0;
      cfg_r.basis_y    <= '0;
      cfg_r.basis_z    <= '0;
      cfg_r.scale      <= pwgm_pkg::SCALE_RST;
      cfg_r.cutoff     <= '0;
      cfg_r.gamma_only <= 1'b0;
      cfg_r.offsets    <= '0;
      cfg_r.dims       <= pwgm_pkg::DIMS_RST;
    end else if (cfg_we) begin
      unique case (pwgm_pkg::reg_idx_t'(cfg_index))
        pwgm_pkg::REG_BASIS_X: cfg_r.basis_x    <= cfg_data[47:0];
        pwgm_pkg::REG_BASIS_Y: cfg_r.basis_y    <= cfg_data[47:0];
        pwgm_pkg::REG_BASIS_Z: cfg_r.basis_z    <= cfg_data[47:0];
        pwgm_pkg::REG_SCALE:   cfg_r.scale      <= cfg_data[15:0];
        pwgm_pkg::REG_CUTOFF:  cfg_r.cutoff     <= cfg_data[47:0];
        pwgm_pkg::REG_GAMMA:   cfg_r.gamma_only <= cfg_data[0];
        pwgm_pkg::REG_OFFSETS: cfg_r.offsets    <= cfg_data[23:0];
        pwgm_pkg::REG_DIMS:    cfg_r.dims       <= cfg_data[26:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> src/pwgm_fold.sv
// Stage 1: offset add, fold into signed FFT range, gamma and Nyquist rejects.
// Depends on pwgm_pkg (cfg_t, fold_t).
`default_nettype none

module pwgm_fold #(
  parameter int MAX_DIM = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pwgm_pkg::cfg_t cfg,
  input  wire logic           vld_i,
  input  wire logic [7:0]     lx_i,
  input  wire logic [7:0]     ly_i,
  input  wire logic [7:0]     lz_i,
  output logic                rdy_o,
  output logic                vld_o,
  output pwgm_pkg::fold_t     dat_o,
  input  wire logic           rdy_i
);

  localparam logic [8:0] DMAX = 9'(MAX_DIM);

  function automatic logic [8:0] dim_of(input logic [8:0] f);
    logic [8:0] d;
    d = f;
    if (d == 9'd0) d = 9'd1;
    if (d > DMAX) d = DMAX;
    return d;
  endfunction

  function automatic logic signed [8:0] fold(input logic [7:0] o, input logic [7:0] l,
                                             input logic [8:0] d);
    logic [9:0]         s;
    logic signed [10:0] t;
    s = {2'b00, o} + {2'b00, l};
    if (s > {2'b00, d[8:1]}) t = $signed({1'b0, s}) - $signed({2'b00, d});
    else                     t = $signed({1'b0, s});
    if (t > 11'sd255) t = 11'sd255;
    return t[8:0];
  endfunction

  function automatic logic at_nyq(input logic signed [8:0] v, input logic [8:0] d);
    logic [8:0] a;
    a = v[8] ? 9'(-v) : v;
    return a == {1'b0, d[8:1]};
  endfunction

  logic            vld_r;
  pwgm_pkg::fold_t dat_r;
  pwgm_pkg::fold_t dat_nxt;
  logic [8:0]      dx, dy, dz;
  logic            gam_rej;

  always_comb begin
    dx = dim_of(cfg.dims[8:0]);
    dy = dim_of(cfg.dims[17:9]);
    dz = dim_of(cfg.dims[26:18]);
    dat_nxt.idx_x = fold(cfg.offsets[7:0],   lx_i, dx);
    dat_nxt.idx_y = fold(cfg.offsets[15:8],  ly_i, dy);
    dat_nxt.idx_z = fold(cfg.offsets[23:16], lz_i, dz);
    // gamma-only keeps the half space x>0, or x=0,y>0, or x=y=0,z>=0
    gam_rej = dat_nxt.idx_x[8]
           || (dat_nxt.idx_x == 9'sd0 && dat_nxt.idx_y[8])
           || (dat_nxt.idx_x == 9'sd0 && dat_nxt.idx_y == 9'sd0 && dat_nxt.idx_z[8]);
    dat_nxt.rej = (cfg.gamma_only && gam_rej)
               || at_nyq(dat_nxt.idx_x, dx)
               || at_nyq(dat_nxt.idx_y, dy)
               || at_nyq(dat_nxt.idx_z, dz);
  end

  assign rdy_o = !vld_r || rdy_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && vld_i) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

`default_nettype wire

>>> src/pwgm_gvec.sv
// Stages 2-4: basis dot products, cell scale multiply, round and saturate to Q12.12.
// Depends on pwgm_pkg (cfg_t, fold_t, gvec_t, dot3).
`default_nettype none

module pwgm_gvec (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pwgm_pkg::cfg_t  cfg,
  input  wire logic            vld_i,
  input  wire pwgm_pkg::fold_t dat_i,
  output logic                 rdy_o,
  output logic                 vld_o,
  output pwgm_pkg::gvec_t      dat_o,
  input  wire logic            rdy_i
);

  // per-stage valid and ready
  logic [2:0] vld_r;
  logic [2:0] rdy;

  assign rdy[2] = !vld_r[2] || rdy_i;
  assign rdy[1] = !vld_r[1] || rdy[2];
  assign rdy[0] = !vld_r[0] || rdy[1];
  assign rdy_o  = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= vld_i;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
    end
  end

  // stage 2: dot products (Q.12)
  pwgm_pkg::fold_t    f2_r;
  logic signed [26:0] acc_r [3];

  always_ff @(posedge clk) begin
    if (rdy[0] && vld_i) begin
      f2_r     <= dat_i;
      acc_r[0] <= pwgm_pkg::dot3(cfg.basis_x, dat_i.idx_x, dat_i.idx_y, dat_i.idx_z);
      acc_r[1] <= pwgm_pkg::dot3(cfg.basis_y, dat_i.idx_x, dat_i.idx_y, dat_i.idx_z);
      acc_r[2] <= pwgm_pkg::dot3(cfg.basis_z, dat_i.idx_x, dat_i.idx_y, dat_i.idx_z);
    end
  end

  // stage 3: scale multiply (Q.20)
  pwgm_pkg::fold_t    f3_r;
  logic signed [43:0] prod_r [3];
  logic signed [43:0] prod_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = acc_r[i] * $signed({1'b0, cfg.scale});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && vld_r[0]) begin
      f3_r <= f2_r;
      for (int i = 0; i < 3; i++) prod_r[i] <= prod_nxt[i];
    end
  end

  // stage 4: round half up, floor shift by 8, saturate to 24 bits
  pwgm_pkg::fold_t    f4_r;
  logic signed [23:0] g_r   [3];
  logic signed [23:0] g_nxt [3];
  logic signed [43:0] rnd   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (prod_r[i] + 44'sd128) >>> 8;
      if (rnd[i] > 44'sd8388607)       g_nxt[i] = pwgm_pkg::G_MAX;
      else if (rnd[i] < -44'sd8388608) g_nxt[i] = pwgm_pkg::G_MIN;
      else                             g_nxt[i] = rnd[i][23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && vld_r[1]) begin
      f4_r <= f3_r;
      for (int i = 0; i < 3; i++) g_r[i] <= g_nxt[i];
    end
  end

  assign vld_o       = vld_r[2];
  assign dat_o.idx_x = f4_r.idx_x;
  assign dat_o.idx_y = f4_r.idx_y;
  assign dat_o.idx_z = f4_r.idx_z;
  assign dat_o.g_x   = g_r[0];
  assign dat_o.g_y   = g_r[1];
  assign dat_o.g_z   = g_r[2];
  assign dat_o.rej   = f4_r.rej;

endmodule

`default_nettype wire

>>> src/pwgm_mag.sv
// Stages 5-6: squares of g, magnitude sum with cutoff test, output register.
// Depends on pwgm_pkg (cfg_t, gvec_t).
`default_nettype none

module pwgm_mag (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pwgm_pkg::cfg_t    cfg,
  input  wire logic              vld_i,
  input  wire pwgm_pkg::gvec_t   dat_i,
  output logic                   rdy_o,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_in_sphere,
  output logic signed [8:0]      out_global_x,
  output logic signed [8:0]      out_global_y,
  output logic signed [8:0]      out_global_z,
  output logic signed [23:0]     out_g_x,
  output logic signed [23:0]     out_g_y,
  output logic signed [23:0]     out_g_z,
  output logic [47:0]            out_magnitude_sq
);

  logic [1:0] vld_r;
  logic [1:0] rdy;

  assign rdy[1] = !vld_r[1] || !out_stall;
  assign rdy[0] = !vld_r[0] || rdy[1];
  assign rdy_o  = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= vld_i;
      if (rdy[1]) vld_r[1] <= vld_r[0];
    end
  end

  // stage 5: squares, |g| <= 2^23 so each fits 47 bits
  pwgm_pkg::gvec_t    gv_r;
  logic [46:0]        sq_r   [3];
  logic [46:0]        sq_nxt [3];
  logic signed [47:0] sq_full [3];

  always_comb begin
    sq_full[0] = dat_i.g_x * dat_i.g_x;
    sq_full[1] = dat_i.g_y * dat_i.g_y;
    sq_full[2] = dat_i.g_z * dat_i.g_z;
    for (int i = 0; i < 3; i++) sq_nxt[i] = sq_full[i][46:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && vld_i) begin
      gv_r <= dat_i;
      for (int i = 0; i < 3; i++) sq_r[i] <= sq_nxt[i];
    end
  end

  // stage 6: sum, saturate, cutoff, zero rejected and out-of-cutoff words
  logic [48:0] sum;
  logic [47:0] mag;
  logic        keep;

  always_comb begin
    sum  = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
    mag  = sum[48] ? '1 : sum[47:0];
    keep = !gv_r.rej && (mag <= cfg.cutoff);
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && vld_r[0]) begin
      out_in_sphere    <= keep;
      out_global_x     <= gv_r.idx_x;
      out_global_y     <= gv_r.idx_y;
      out_global_z     <= gv_r.idx_z;
      out_g_x          <= keep ? gv_r.g_x : '0;
      out_g_y          <= keep ? gv_r.g_y : '0;
      out_g_z          <= keep ? gv_r.g_z : '0;
      out_magnitude_sq <= keep ? mag : '0;
    end
  end

  assign out_valid = vld_r[1];

endmodule

`default_nettype wire

>>> src/pwgm_chk.sv
// Port-level checker for plane_wave_gvector_mask, attached by bind below.
// Depends on pwgm_pkg for the configuration port widths.
`default_nettype none

module pwgm_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            cfg_we,
  input wire logic [pwgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [pwgm_pkg::CFG_DATA_W-1:0] cfg_data,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic [7:0]                      in_local_x,
  input wire logic [7:0]                      in_local_y,
  input wire logic [7:0]                      in_local_z,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic                            out_in_sphere,
  input wire logic signed [8:0]               out_global_x,
  input wire logic signed [8:0]               out_global_y,
  input wire logic signed [8:0]               out_global_z,
  input wire logic signed [23:0]              out_g_x,
  input wire logic signed [23:0]              out_g_y,
  input wire logic signed [23:0]              out_g_z,
  input wire logic [47:0]                     out_magnitude_sq
);

  // pipeline comes out of reset empty
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  // input can only back up when every stage is full and the output is stalled
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while pipeline has room");

  // a rejected point carries no g-vector and no magnitude
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_sphere) |->
      (out_g_x == '0 && out_g_y == '0 && out_g_z == '0 && out_magnitude_sq == '0))
    else $error("rejected word has nonzero g or magnitude");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_in_sphere) && $stable(out_global_x)
       && $stable(out_global_y) && $stable(out_global_z) && $stable(out_g_x)
       && $stable(out_g_y) && $stable(out_g_z) && $stable(out_magnitude_sq)))
    else $error("stalled output word changed");

endmodule

bind plane_wave_gvector_mask pwgm_chk u_pwgm_chk (.*);

`default_nettype wire
